>>> rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table: request
// codes, slot tags, controller states and the layout of one table entry.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VALUE_W = 64;
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_HASH  = 2'd2,
    ST_PROBE = 2'd3
  } state_t;

  typedef struct packed {
    tag_t               tag;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

endpackage

>>> rtl/core/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Fixed-capacity open-addressing hash table with linear probing and
// tombstones. Set, get and remove requests walk a single-port-read table
// memory one slot per cycle; sets and removes then write the chosen slot.
// ----------------------------------------------------------------------------
//  Channel   Signals                                        Handshake
//  --------  ---------------------------------------------  -------------------
//  request   command, key_id, key_hash, write_value         start && !busy
//  result    success, read_value                            done, one cycle
//
//  A request probes from 1 to CAPACITY slots; the table memory returns one
//  slot per cycle once the hash reduction has given the home slot.
//  A request that needs no probe (unused code, lookup in an empty table)
//  is answered as soon as the hash reduction ends.
//  Reset: a clearing pass marks every slot empty; busy stays high until it
//  ends. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpht_pkg::CMD_W-1:0]    command,
  input  logic [lpht_pkg::KEY_W-1:0]    key_id,
  input  logic [lpht_pkg::HASH_W-1:0]   key_hash,
  input  logic [lpht_pkg::VALUE_W-1:0]  write_value,
  output logic                          done,
  output logic                          success,
  output logic [lpht_pkg::VALUE_W-1:0]  read_value
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

  // Controller state
  state_t             state, state_next;
  cmd_t               cmd;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   cur, cur_next;
  logic [IDX_W-1:0]   steps, steps_next;
  logic               tomb_seen, tomb_seen_next;
  logic [IDX_W-1:0]   tomb_slot, tomb_slot_next;
  logic [OCC_W-1:0]   occ, occ_next;
  logic [IDX_W-1:0]   clr_addr, clr_addr_next;
  logic               done_next, success_next;
  logic [VALUE_W-1:0] read_value_next;

  // Table memory ports
  slot_t              mem [CAPACITY];
  slot_t              rdata;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_t              wr_data;

  // Hash reduction
  logic               accept;
  logic               hm_done;
  logic [IDX_W-1:0]   hm_slot;
  logic [IDX_W-1:0]   nxt;
  logic               hit, empty, last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  lpht_hmod #(
    .CAPACITY(CAPACITY)
  ) u_hmod (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .hash (key_hash),
    .done (hm_done),
    .slot (hm_slot)
  );

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Probe decode of the slot returned this cycle
  assign nxt   = (cur == LAST) ? '0 : cur + IDX_W'(1);
  assign empty = (rdata.tag == TAG_EMPTY);
  assign hit   = (rdata.tag == TAG_LIVE) && (rdata.key == key);
  assign last  = (steps == LAST);

  // Next state, memory access and result
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    steps_next      = steps;
    tomb_seen_next  = tomb_seen;
    tomb_slot_next  = tomb_slot;
    occ_next        = occ;
    clr_addr_next   = clr_addr;
    done_next       = 1'b0;
    success_next    = 1'b0;
    read_value_next = '0;
    rd_addr         = nxt;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = '{tag: TAG_EMPTY, key: '0, value: '0};

    unique case (state)
      ST_CLEAR: begin
        // Sweep every slot to empty
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == LAST) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        // Issue the read of the home slot, or answer at once
        if (hm_done) begin
          if ((cmd == CMD_SET) ||
              (((cmd == CMD_GET) || (cmd == CMD_REMOVE)) && (occ != '0))) begin
            rd_addr        = hm_slot;
            cur_next       = hm_slot;
            steps_next     = '0;
            tomb_seen_next = 1'b0;
            state_next     = ST_PROBE;
          end else begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_PROBE: begin
        if (cmd == CMD_SET) begin
          if (empty || hit) begin
            // Store into first tombstone, the empty slot, or the live match
            wr_en        = 1'b1;
            wr_addr      = (empty && tomb_seen) ? tomb_slot : cur;
            wr_data      = '{tag: TAG_LIVE, key: key, value: value};
            if (empty && !tomb_seen) begin
              occ_next = occ + OCC_W'(1);
            end
            done_next    = 1'b1;
            success_next = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            if (!tomb_seen && (rdata.tag == TAG_TOMB)) begin
              tomb_seen_next = 1'b1;
              tomb_slot_next = cur;
            end
            if (last) begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cur_next   = nxt;
              steps_next = steps + IDX_W'(1);
            end
          end
        end else begin
          if (empty) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else if (hit) begin
            done_next    = 1'b1;
            success_next = 1'b1;
            state_next   = ST_IDLE;
            if (cmd == CMD_GET) begin
              read_value_next = rdata.value;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cur;
              wr_data = '{tag: TAG_TOMB, key: '0, value: '0};
            end
          end else if (last) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cur_next   = nxt;
            steps_next = steps + IDX_W'(1);
          end
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      occ      <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  // Request and probe registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= cmd_t'(command);
      key   <= key_id;
      value <= write_value;
    end
    cur        <= cur_next;
    steps      <= steps_next;
    tomb_seen  <= tomb_seen_next;
    tomb_slot  <= tomb_slot_next;
    success    <= success_next;
    read_value <= read_value_next;
  end

endmodule

>>> rtl/core/lpht_hmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hmod
// Reduces a key hash to its home slot, hash mod CAPACITY. A power-of-two
// capacity takes the low bits, registered. Any other capacity uses a
// three-stage reciprocal reduction: estimate the quotient, take the
// remainder, then correct it with one compare and subtract.
// ----------------------------------------------------------------------------
module lpht_hmod #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpht_pkg::HASH_W-1:0]  hash,
  output logic                         done,
  output logic [$clog2(CAPACITY)-1:0]  slot
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
    // Take the low bits of the hash
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        slot <= hash[IDX_W-1:0];
      end
    end
  end else begin : g_recip
    // Scaled reciprocal of the capacity; the quotient estimate it gives is
    // low by at most one, so the first remainder is below twice the capacity
    localparam logic [HASH_W-1:0] RECIP =
      HASH_W'((64'd1 << HASH_W) / 64'(CAPACITY));
    localparam logic [HASH_W-1:0] CAP = HASH_W'(CAPACITY);

    logic [2*HASH_W-1:0] prod;
    logic [HASH_W-1:0]   hash_q;
    logic [HASH_W-1:0]   quot;
    logic [HASH_W-1:0]   rem_est;
    logic [HASH_W-1:0]   rem_fix;
    logic                prod_vld;
    logic                rem_vld;
    logic [IDX_W-1:0]    slot_r;

    assign quot    = prod[2*HASH_W-1:HASH_W];
    assign rem_fix = (rem_est >= CAP) ? (rem_est - CAP) : rem_est;

    // Advance the valid marks through the three stages
    always_ff @(posedge clk) begin
      if (rst) begin
        prod_vld <= 1'b0;
        rem_vld  <= 1'b0;
        done     <= 1'b0;
      end else begin
        prod_vld <= start;
        rem_vld  <= prod_vld;
        done     <= rem_vld;
      end
    end

    // Estimate the quotient, take the remainder, then correct it once
    always_ff @(posedge clk) begin
      prod    <= (2*HASH_W)'(hash) * (2*HASH_W)'(RECIP);
      hash_q  <= hash;
      rem_est <= hash_q - quot * CAP;
      slot_r  <= rem_fix[IDX_W-1:0];
    end

    assign slot = slot_r;
  end

endmodule

>>> rtl/core/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the hash table: request acceptance, result timing and
// the zero value on failed results.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          success,
  input logic [lpht_pkg::VALUE_W-1:0]  read_value
);
  import lpht_pkg::*;

  // Hold busy after an accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted request");

  // Drop busy while the result is shown
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Show a result only after work on a request
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // Return zero on a failed request
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (read_value == '0))
    else $error("nonzero read_value on a failed request");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .success   (success),
  .read_value(read_value)
);

>>> sim/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. A table of directed
// requests covers the empty table, the widest fields, collisions, wraparound,
// tombstone reuse and the unused code. Random traffic follows on a small key
// pool. The table is then filled to no empty slot, and random traffic runs on
// the full table. A shadow table predicts every unpinned result, and the
// results are checked in order as they arrive.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int SLOT_W       = $clog2(CAPACITY);
  localparam int POOL_SIZE    = 24;
  localparam int MIXED_ITEMS  = 200;
  localparam int FULL_ITEMS   = 80;
  localparam int SETTLE_CYCLES = CAPACITY + 40;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int NUM_ROWS     = 24;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0]   KEY_ONES   = '1;
  localparam logic [HASH_W-1:0]  HASH_ONES  = '1;
  localparam logic [VALUE_W-1:0] VALUE_ONES = '1;
  localparam logic [VALUE_W-1:0] VALUE_A    = 64'hA5A5_5A5A_0123_4567;
  localparam logic [VALUE_W-1:0] VALUE_B    = 64'h0F0F_F0F0_89AB_CDEF;
  localparam logic [VALUE_W-1:0] VALUE_C    = 64'h8000_0000_0000_0001;
  localparam logic [VALUE_W-1:0] VALUE_D    = 64'h5555_AAAA_3333_CCCC;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] wval;
    bit                 pinned;
    bit                 ok;
    logic [VALUE_W-1:0] rval;
  } stim_row_t;

  typedef struct {
    bit                 ok;
    logic [VALUE_W-1:0] value;
  } lookup_outcome_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic [CMD_W-1:0]   command     = '0;
  logic [KEY_W-1:0]   key_id      = '0;
  logic [HASH_W-1:0]  key_hash    = '0;
  logic [VALUE_W-1:0] write_value = '0;
  logic               busy;
  logic               done;
  logic               success;
  logic [VALUE_W-1:0] read_value;

  linear_probe_hash_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .key_id(key_id),
    .key_hash(key_hash),
    .write_value(write_value),
    .done(done),
    .success(success),
    .read_value(read_value)
  );

  // Shadow copy of the table
  tag_t               shadow_tag   [CAPACITY];
  logic [KEY_W-1:0]   shadow_key   [CAPACITY];
  logic [VALUE_W-1:0] shadow_value [CAPACITY];
  int unsigned        shadow_filled;

  lookup_outcome_t    pending_outcomes [$];
  int unsigned        error_count = 0;
  int                 burst_left  = 0;

  logic [KEY_W-1:0]   pool_key  [POOL_SIZE];
  logic [HASH_W-1:0]  pool_hash [POOL_SIZE];

  // Directed requests; pinned rows carry a result that is plain by eye
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_GET,    32'h1234_5678, 32'h0,         VALUE_ONES, 1'b1, 1'b0, 64'h0},
    '{CMD_REMOVE, 32'h1234_5678, 32'h0,         64'h0,      1'b1, 1'b0, 64'h0},
    '{CMD_UNUSED, KEY_ONES,      HASH_ONES,     VALUE_ONES, 1'b1, 1'b0, 64'h0},
    '{CMD_SET,    KEY_ONES,      HASH_ONES,     VALUE_ONES, 1'b1, 1'b1, 64'h0},
    '{CMD_GET,    KEY_ONES,      HASH_ONES,     64'h0,      1'b1, 1'b1, VALUE_ONES},
    '{CMD_SET,    32'h0,         32'h0,         64'h0,      1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h0,         32'h0,         VALUE_A,    1'b1, 1'b1, 64'h0},
    '{CMD_SET,    32'h1,         32'h0,         VALUE_A,    1'b1, 1'b1, 64'h0},
    '{CMD_SET,    32'h2,         32'h100,       VALUE_B,    1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h2,         32'h100,       64'h0,      1'b1, 1'b1, VALUE_B},
    '{CMD_REMOVE, 32'h1,         32'h0,         VALUE_C,    1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h2,         32'h0,         64'h0,      1'b1, 1'b1, VALUE_B},
    '{CMD_GET,    32'h1,         32'h0,         64'h0,      1'b1, 1'b0, 64'h0},
    '{CMD_REMOVE, 32'h1,         32'h0,         64'h0,      1'b1, 1'b0, 64'h0},
    '{CMD_SET,    32'h3,         32'h0,         VALUE_C,    1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h3,         32'h1,         64'h0,      1'b0, 1'b0, 64'h0},
    '{CMD_SET,    32'h2,         32'h0,         VALUE_D,    1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h2,         32'h0,         64'h0,      1'b0, 1'b0, 64'h0},
    '{CMD_SET,    32'h5,         32'hFF,        VALUE_A,    1'b0, 1'b0, 64'h0},
    '{CMD_GET,    32'h5,         32'hFF,        64'h0,      1'b0, 1'b0, 64'h0},
    '{CMD_REMOVE, KEY_ONES,      HASH_ONES,     64'h0,      1'b1, 1'b1, 64'h0},
    '{CMD_GET,    32'h5,         32'hFF,        64'h0,      1'b0, 1'b0, 64'h0},
    '{CMD_GET,    32'hDEAD_BEEF, 32'hAAAA_5555, VALUE_ONES, 1'b0, 1'b0, 64'h0},
    '{CMD_REMOVE, 32'h0,         32'h0,         64'h0,      1'b1, 1'b1, 64'h0}
  };

  // Slot a set writes: first tombstone before an empty slot, the empty slot,
  // or a live match; -1 after a sweep with neither
  function automatic int set_target(logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    int s;
    int i;
    int pick;
    int tomb;
    s = int'(hash % 32'(CAPACITY));
    pick = -1;
    tomb = -1;
    for (i = 0; i < CAPACITY && pick < 0; i++) begin
      if (tomb < 0 && shadow_tag[s] == TAG_TOMB) tomb = s;
      if (shadow_tag[s] == TAG_EMPTY) pick = (tomb >= 0) ? tomb : s;
      else if (shadow_tag[s] == TAG_LIVE && shadow_key[s] == key) pick = s;
      s = (s + 1) % CAPACITY;
    end
    return pick;
  endfunction

  // Live slot holding the key; skip tombstones, stop at an empty slot
  function automatic int live_slot_of(logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    int s;
    int i;
    int hit;
    bit stop;
    s = int'(hash % 32'(CAPACITY));
    hit = -1;
    stop = (shadow_filled == 0);
    for (i = 0; i < CAPACITY && !stop; i++) begin
      if (shadow_tag[s] == TAG_EMPTY) begin
        stop = 1'b1;
      end else if (shadow_tag[s] == TAG_LIVE && shadow_key[s] == key) begin
        hit = s;
        stop = 1'b1;
      end
      s = (s + 1) % CAPACITY;
    end
    return hit;
  endfunction

  // Apply one request to the shadow table and return its outcome
  function automatic lookup_outcome_t apply_request(logic [CMD_W-1:0] cmd,
                                                    logic [KEY_W-1:0] key,
                                                    logic [HASH_W-1:0] hash,
                                                    logic [VALUE_W-1:0] wval);
    lookup_outcome_t r;
    int s;
    r.ok = 1'b0;
    r.value = '0;
    case (cmd)
      CMD_SET: begin
        s = set_target(key, hash);
        if (s >= 0) begin
          if (shadow_tag[s] == TAG_EMPTY) shadow_filled++;
          shadow_tag[s] = TAG_LIVE;
          shadow_key[s] = key;
          shadow_value[s] = wval;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        s = live_slot_of(key, hash);
        if (s >= 0) begin
          r.ok = 1'b1;
          r.value = shadow_value[s];
        end
      end
      CMD_REMOVE: begin
        s = live_slot_of(key, hash);
        if (s >= 0) begin
          shadow_tag[s] = TAG_TOMB;
          shadow_key[s] = '0;
          shadow_value[s] = '0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int random_slot_tagged(tag_t want);
    int s;
    int i;
    int hit;
    hit = -1;
    s = $urandom_range(0, CAPACITY - 1);
    for (i = 0; i < CAPACITY && hit < 0; i++) begin
      if (shadow_tag[s] == want) hit = s;
      s = (s + 1) % CAPACITY;
    end
    return hit;
  endfunction

  function automatic bit key_is_live(logic [KEY_W-1:0] key);
    int i;
    bit hit;
    hit = 1'b0;
    for (i = 0; i < CAPACITY; i++)
      if (shadow_tag[i] == TAG_LIVE && shadow_key[i] == key) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic [KEY_W-1:0] absent_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    while (key_is_live(k)) k = $urandom;
    return k;
  endfunction

  function automatic logic [CMD_W-1:0] random_command(int set_pct, int get_pct,
                                                      int remove_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < set_pct) return CMD_SET;
    if (sel < set_pct + get_pct) return CMD_GET;
    if (sel < set_pct + get_pct + remove_pct) return CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  // Offer one request, hold it until accepted, then pace the next one
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash,
                              input logic [VALUE_W-1:0] wval, input bit pinned,
                              input bit pin_ok, input logic [VALUE_W-1:0] pin_val);
    lookup_outcome_t r;
    int gap;
    start <= 1'b1;
    command <= cmd;
    key_id <= key;
    key_hash <= hash;
    write_value <= wval;
    do @(posedge clk); while (busy);
    r = apply_request(cmd, key, hash, wval);
    if (pinned) begin
      r.ok = pin_ok;
      r.value = pin_val;
    end
    pending_outcomes.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every outstanding request has its result
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Check each result against the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    lookup_outcome_t want;
    if (!rst && done === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        error_count++;
        $error("result with no request outstanding: success %0b read_value %h",
               success, read_value);
      end else begin
        want = pending_outcomes.pop_front();
        if (success !== want.ok) begin
          error_count++;
          $error("success: expected %0b, got %0b", want.ok, success);
        end
        if (read_value !== want.value) begin
          error_count++;
          $error("read_value: expected %h, got %h", want.value, read_value);
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int p;
    int s;
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] h;

    for (n = 0; n < CAPACITY; n++) begin
      shadow_tag[n] = TAG_EMPTY;
      shadow_key[n] = '0;
      shadow_value[n] = '0;
    end
    shadow_filled = 0;

    // Half the pool clusters around the wrap point, half hashes anywhere
    for (p = 0; p < POOL_SIZE; p++) begin
      pool_key[p] = $urandom;
      h = $urandom;
      if (p % 2 == 0) h[SLOT_W-1:0] = SLOT_W'((224 + $urandom_range(0, 47)) % CAPACITY);
      pool_hash[p] = h;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests
    for (n = 0; n < NUM_ROWS; n++)
      send_request(directed_rows[n].cmd, directed_rows[n].key, directed_rows[n].hash,
                   directed_rows[n].wval, directed_rows[n].pinned, directed_rows[n].ok,
                   directed_rows[n].rval);

    // Mixed traffic on a small key pool, with some stray keys and hashes
    for (n = 0; n < MIXED_ITEMS; n++) begin
      cmd = random_command(40, 35, 20);
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        key = pool_key[p];
        hash = ($urandom_range(0, 9) == 0) ? HASH_W'($urandom) : pool_hash[p];
      end else begin
        key = $urandom;
        hash = $urandom;
      end
      send_request(cmd, key, hash, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    end

    // Fill every empty slot, aiming each new key straight at one
    wait_all_results();
    while (random_slot_tagged(TAG_EMPTY) >= 0) begin
      s = random_slot_tagged(TAG_EMPTY);
      h = $urandom;
      h[SLOT_W-1:0] = s[SLOT_W-1:0];
      send_request(CMD_SET, absent_key(), h, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    end

    // Full table: failed set, absent get after a full sweep, tombstones
    send_request(CMD_SET, absent_key(), $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    send_request(CMD_GET, absent_key(), $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    repeat (3) begin
      s = random_slot_tagged(TAG_LIVE);
      h = $urandom;
      h[SLOT_W-1:0] = s[SLOT_W-1:0];
      send_request(CMD_REMOVE, shadow_key[s], h, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    end
    send_request(CMD_SET, absent_key(), $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    s = random_slot_tagged(TAG_LIVE);
    key = shadow_key[s];
    send_request(CMD_SET, key, $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    send_request(CMD_GET, key, $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);

    // Random traffic on the full table, mostly on keys it holds
    for (n = 0; n < FULL_ITEMS; n++) begin
      cmd = random_command(30, 40, 25);
      s = random_slot_tagged(TAG_LIVE);
      hash = $urandom;
      if ($urandom_range(0, 99) < 65 && s >= 0) begin
        key = shadow_key[s];
        if ($urandom_range(0, 1) == 0) hash[SLOT_W-1:0] = s[SLOT_W-1:0];
      end else begin
        key = $urandom;
      end
      send_request(cmd, key, hash, {$urandom, $urandom}, 1'b0, 1'b0, '0);
    end

    // Drain, then allow time for any stray result
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> linear_probe_hash_table.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_hmod.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
sim/linear_probe_hash_table_tb.sv
